// ===== rtl/nnsag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsag_pkg
// Shared widths, register codes and reset values for the nearest-neighbour
// scaling address generator.
// ----------------------------------------------------------------------------
package nnsag_pkg;

    localparam int MAX_DIM   = 2048;
    localparam int DIM_W     = $clog2(MAX_DIM) + 1;
    localparam int IDX_W     = 2 * $clog2(MAX_DIM);
    localparam int REM_W     = DIM_W + 1;
    localparam int ERR_W     = DIM_W + 2;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int CFG_NUM   = 4;
    localparam int CFG_IDX_W = $clog2(CFG_NUM);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_DST_WIDTH  = 2'd1,
        REG_SRC_HEIGHT = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = DIM_W'(320);
    localparam logic [DIM_W-1:0] DST_WIDTH_RST  = DIM_W'(80);
    localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = DIM_W'(200);
    localparam logic [DIM_W-1:0] DST_HEIGHT_RST = DIM_W'(25);

endpackage

// ===== rtl/nnsag_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsag_if
// Valid/ready channels: the command item in and the address item out.
// ----------------------------------------------------------------------------
interface nnsag_cmd_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface nnsag_addr_if import nnsag_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] src_index;
    logic [IDX_W-1:0] dst_index;
    logic             frame_last;

    modport source (output valid, output src_index, output dst_index, output frame_last,
                    input ready);
    modport sink   (input valid, input src_index, input dst_index, input frame_last,
                    output ready);
endinterface

// ===== rtl/nearest_neighbor_scale_addr_gen_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_addr_gen_core
// Nearest-neighbour scaling address generator with per-axis error
// accumulation; at most one source/destination index pair per command item.
// ----------------------------------------------------------------------------
// Takes one command item per clock while ready is high and returns at most one
// address item per command, through a single output register, so a full frame
// streams at one pixel per cycle unless stalled. A restart item starts a new
// frame and yields destination pixel zero at once. The whole step and remainder
// of each axis come from the size registers through one shared restoring
// divider (one quotient bit per cycle, width then height) and one multiply:
// after reset and after every configuration write the command port holds
// ready low while these are worked out. Size changes apply at the next restart.
module nearest_neighbor_scale_addr_gen_core
    import nnsag_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    nnsag_cmd_if.sink            cmd,
    nnsag_addr_if.source         addr
);

    localparam int DIV_CNT_W = $clog2(DIM_W);

    typedef enum logic [2:0] {
        PC_START,
        PC_DIV_X,
        PC_DIV_Y,
        PC_MUL,
        PC_IDLE
    } pc_state_t;

    // configuration
    logic [DIM_W-1:0] sw_reg, dw_reg, sh_reg, dh_reg;

    // step precompute
    pc_state_t              pc_state_reg, pc_state_next;
    logic [DIM_W-1:0]       div_num_reg, div_num_next;
    logic [DIM_W-1:0]       div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [DIM_W-1:0]       pc_step_x_reg, pc_step_x_next;
    logic [REM_W-1:0]       pc_rem_x_reg, pc_rem_x_next;
    logic [DIM_W-1:0]       pc_qy_reg, pc_qy_next;
    logic [REM_W-1:0]       pc_rem_y_reg, pc_rem_y_next;
    logic [IDX_W-1:0]       pc_step_y_reg, pc_step_y_next;

    // frame state
    logic                     active_reg, active_next;
    logic [IDX_W-1:0]         src_ptr_reg, src_ptr_next;
    logic [IDX_W-1:0]         row_base_reg, row_base_next;
    logic [IDX_W-1:0]         dst_ptr_reg, dst_ptr_next;
    logic signed [ERR_W-1:0]  err_x_reg, err_x_next;
    logic signed [ERR_W-1:0]  err_y_reg, err_y_next;
    logic [DIM_W-1:0]         col_left_reg, col_left_next;
    logic [DIM_W-1:0]         rows_left_reg, rows_left_next;
    logic [DIM_W-1:0]         step_x_reg, step_x_next;
    logic [REM_W-1:0]         rem_x_reg, rem_x_next;
    logic [IDX_W-1:0]         step_y_reg, step_y_next;
    logic [REM_W-1:0]         rem_y_reg, rem_y_next;
    logic [DIM_W-1:0]         lat_sw_reg, lat_sw_next;
    logic [DIM_W-1:0]         lat_dw_reg, lat_dw_next;
    logic [DIM_W-1:0]         lat_dh_reg, lat_dh_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_src_reg, out_src_next;
    logic [IDX_W-1:0] out_dst_reg, out_dst_next;
    logic             out_last_reg, out_last_next;

    // divider datapath
    logic [DIM_W-1:0]  div_den;
    logic [DIM_W:0]    div_trial;
    logic [DIM_W:0]    div_diff;
    logic              div_ge;
    logic [DIM_W-1:0]  div_rem_iter;
    logic [DIM_W-1:0]  div_num_iter;
    logic              div_last;
    logic              x_shrink, y_shrink;
    logic [PROD_W-1:0] pc_prod;

    // pixel step datapath
    logic                     accept;
    logic                     zero_size;
    logic                     cur_active;
    logic [IDX_W-1:0]         cur_src, cur_row, cur_dst;
    logic signed [ERR_W-1:0]  cur_err_x, cur_err_y;
    logic [DIM_W-1:0]         cur_col, cur_rows;
    logic [DIM_W-1:0]         cur_step_x, cur_sw, cur_dw, cur_dh;
    logic [REM_W-1:0]         cur_rem_x, cur_rem_y;
    logic [IDX_W-1:0]         cur_step_y;
    logic signed [ERR_W-1:0]  dx_s, dy_s;
    logic signed [ERR_W-1:0]  ex_sum, ey_sum;
    logic [IDX_W-1:0]         src_adv;
    logic [IDX_W-1:0]         row_adv;
    logic [DIM_W-1:0]         col_dec, rows_dec;
    logic                     frame_last;

    assign cmd.ready       = (pc_state_reg == PC_IDLE) && (!out_valid_reg || addr.ready);
    assign accept          = cmd.valid && cmd.ready;
    assign addr.valid      = out_valid_reg;
    assign addr.src_index  = out_src_reg;
    assign addr.dst_index  = out_dst_reg;
    assign addr.frame_last = out_last_reg;

    // ---- shared restoring divider ----
    assign div_den      = (pc_state_reg == PC_DIV_Y) ? dh_reg : dw_reg;
    assign div_trial    = {div_rem_reg, div_num_reg[DIM_W-1]};
    assign div_ge       = div_trial >= {1'b0, div_den};
    assign div_diff     = div_trial - {1'b0, div_den};
    assign div_rem_iter = div_ge ? div_diff[DIM_W-1:0] : div_trial[DIM_W-1:0];
    assign div_num_iter = {div_num_reg[DIM_W-2:0], div_ge};
    assign div_last     = div_cnt_reg == DIV_CNT_W'(DIM_W - 1);
    assign x_shrink     = dw_reg < sw_reg;
    assign y_shrink     = dh_reg < sh_reg;
    assign pc_prod      = pc_qy_reg * sw_reg;

    always_comb
    begin
        pc_state_next  = pc_state_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        div_cnt_next   = div_cnt_reg;
        pc_step_x_next = pc_step_x_reg;
        pc_rem_x_next  = pc_rem_x_reg;
        pc_qy_next     = pc_qy_reg;
        pc_rem_y_next  = pc_rem_y_reg;
        pc_step_y_next = pc_step_y_reg;
        case (pc_state_reg)
            PC_START:
            begin
                div_num_next  = sw_reg;
                div_rem_next  = '0;
                div_cnt_next  = '0;
                pc_state_next = PC_DIV_X;
            end
            PC_DIV_X:
            begin
                div_num_next = div_num_iter;
                div_rem_next = div_rem_iter;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    pc_step_x_next = x_shrink ? div_num_iter : '0;
                    pc_rem_x_next  = x_shrink ? {div_rem_iter, 1'b0} : {sw_reg, 1'b0};
                    div_num_next   = sh_reg;
                    div_rem_next   = '0;
                    div_cnt_next   = '0;
                    pc_state_next  = PC_DIV_Y;
                end
            end
            PC_DIV_Y:
            begin
                div_num_next = div_num_iter;
                div_rem_next = div_rem_iter;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    pc_qy_next    = div_num_iter;
                    pc_rem_y_next = y_shrink ? {div_rem_iter, 1'b0} : {sh_reg, 1'b0};
                    pc_state_next = PC_MUL;
                end
            end
            PC_MUL:
            begin
                pc_step_y_next = y_shrink ? pc_prod[IDX_W-1:0] : '0;
                pc_state_next  = PC_IDLE;
            end
            PC_IDLE:
            begin
                pc_state_next = PC_IDLE;
            end
            default:
            begin
                pc_state_next = PC_START;
            end
        endcase
        if (cfg_we)
        begin
            pc_state_next = PC_START;
        end
    end

    // ---- pixel step: restart picks frame-start values ----
    assign zero_size = (sw_reg == '0) || (dw_reg == '0) || (sh_reg == '0) || (dh_reg == '0);

    always_comb
    begin
        if (cmd.restart)
        begin
            cur_active = !zero_size;
            cur_src    = '0;
            cur_row    = '0;
            cur_dst    = '0;
            cur_err_x  = -$signed({1'b0, dw_reg, 1'b0});
            cur_err_y  = -$signed({1'b0, dh_reg, 1'b0});
            cur_col    = dw_reg;
            cur_rows   = dh_reg;
            cur_step_x = pc_step_x_reg;
            cur_rem_x  = pc_rem_x_reg;
            cur_step_y = pc_step_y_reg;
            cur_rem_y  = pc_rem_y_reg;
            cur_sw     = sw_reg;
            cur_dw     = dw_reg;
            cur_dh     = dh_reg;
        end
        else
        begin
            cur_active = active_reg;
            cur_src    = src_ptr_reg;
            cur_row    = row_base_reg;
            cur_dst    = dst_ptr_reg;
            cur_err_x  = err_x_reg;
            cur_err_y  = err_y_reg;
            cur_col    = col_left_reg;
            cur_rows   = rows_left_reg;
            cur_step_x = step_x_reg;
            cur_rem_x  = rem_x_reg;
            cur_step_y = step_y_reg;
            cur_rem_y  = rem_y_reg;
            cur_sw     = lat_sw_reg;
            cur_dw     = lat_dw_reg;
            cur_dh     = lat_dh_reg;
        end
    end

    assign dx_s       = $signed({1'b0, cur_dw, 1'b0});
    assign dy_s       = $signed({1'b0, cur_dh, 1'b0});
    assign ex_sum     = cur_err_x + $signed({1'b0, cur_rem_x});
    assign ey_sum     = cur_err_y + $signed({1'b0, cur_rem_y});
    assign src_adv    = cur_src + IDX_W'(cur_step_x) + IDX_W'(ex_sum > 0);
    assign row_adv    = cur_row + cur_step_y + ((ey_sum > 0) ? IDX_W'(cur_sw) : '0);
    assign col_dec    = cur_col - 1'b1;
    assign rows_dec   = cur_rows - 1'b1;
    assign frame_last = (cur_rows == DIM_W'(1)) && (cur_col == DIM_W'(1));

    always_comb
    begin
        src_ptr_next   = src_adv;
        row_base_next  = cur_row;
        dst_ptr_next   = cur_dst + 1'b1;
        err_x_next     = (ex_sum > 0) ? ex_sum - dx_s : ex_sum;
        err_y_next     = cur_err_y;
        col_left_next  = col_dec;
        rows_left_next = cur_rows;
        step_x_next    = cur_step_x;
        rem_x_next     = cur_rem_x;
        step_y_next    = cur_step_y;
        rem_y_next     = cur_rem_y;
        lat_sw_next    = cur_sw;
        lat_dw_next    = cur_dw;
        lat_dh_next    = cur_dh;
        active_next    = active_reg;
        if (accept)
        begin
            active_next = cur_active;
        end
        if (col_dec == '0)
        begin
            row_base_next  = row_adv;
            err_y_next     = (ey_sum > 0) ? ey_sum - dy_s : ey_sum;
            src_ptr_next   = row_adv;
            rows_left_next = rows_dec;
            col_left_next  = cur_dw;
            err_x_next     = -dx_s;
            if (accept && rows_dec == '0)
            begin
                active_next = 1'b0;
            end
        end
    end

    // ---- output register ----
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_src_next   = out_src_reg;
        out_dst_next   = out_dst_reg;
        out_last_next  = out_last_reg;
        if (accept)
        begin
            out_valid_next = cur_active;
            out_src_next   = cur_src;
            out_dst_next   = cur_dst;
            out_last_next  = frame_last;
        end
        else if (addr.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg        <= SRC_WIDTH_RST;
            dw_reg        <= DST_WIDTH_RST;
            sh_reg        <= SRC_HEIGHT_RST;
            dh_reg        <= DST_HEIGHT_RST;
            pc_state_reg  <= PC_START;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SRC_WIDTH:  sw_reg <= cfg_data;
                    REG_DST_WIDTH:  dw_reg <= cfg_data;
                    REG_SRC_HEIGHT: sh_reg <= cfg_data;
                    REG_DST_HEIGHT: dh_reg <= cfg_data;
                    default:        sw_reg <= sw_reg;
                endcase
            end
            pc_state_reg  <= pc_state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_num_reg   <= div_num_next;
        div_rem_reg   <= div_rem_next;
        div_cnt_reg   <= div_cnt_next;
        pc_step_x_reg <= pc_step_x_next;
        pc_rem_x_reg  <= pc_rem_x_next;
        pc_qy_reg     <= pc_qy_next;
        pc_rem_y_reg  <= pc_rem_y_next;
        pc_step_y_reg <= pc_step_y_next;
        out_src_reg   <= out_src_next;
        out_dst_reg   <= out_dst_next;
        out_last_reg  <= out_last_next;
        if (accept && cur_active)
        begin
            src_ptr_reg   <= src_ptr_next;
            row_base_reg  <= row_base_next;
            dst_ptr_reg   <= dst_ptr_next;
            err_x_reg     <= err_x_next;
            err_y_reg     <= err_y_next;
            col_left_reg  <= col_left_next;
            rows_left_reg <= rows_left_next;
            step_x_reg    <= step_x_next;
            rem_x_reg     <= rem_x_next;
            step_y_reg    <= step_y_next;
            rem_y_reg     <= rem_y_next;
            lat_sw_reg    <= lat_sw_next;
            lat_dw_reg    <= lat_dw_next;
            lat_dh_reg    <= lat_dh_next;
        end
    end

endmodule

// ===== rtl/nnsag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsag_checker
// Port-level checks on the address generator, bound to the core module.
// ----------------------------------------------------------------------------
module nnsag_checker
    import nnsag_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_we,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input logic             addr_valid,
    input logic             addr_ready,
    input logic [IDX_W-1:0] addr_src_index,
    input logic [IDX_W-1:0] addr_dst_index,
    input logic             addr_frame_last
);

    logic             prev_valid_reg;
    logic [IDX_W-1:0] prev_dst_reg;
    logic             prev_last_reg;
    logic             addr_acc;

    assign addr_acc = addr_valid && addr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_dst_reg   <= '0;
            prev_last_reg  <= 1'b0;
        end
        else if (addr_acc)
        begin
            prev_valid_reg <= 1'b1;
            prev_dst_reg   <= addr_dst_index;
            prev_last_reg  <= addr_frame_last;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        addr_valid && !addr_ready |=> addr_valid && $stable(addr_src_index)
            && $stable(addr_dst_index) && $stable(addr_frame_last))
        else $error("address item changed while stalled");

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !cmd_ready)
        else $error("command accepted while steps are recomputed");

    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(addr_valid) |-> $past(cmd_valid && cmd_ready))
        else $error("address item without a command item");

    a_dst_seq: assert property (@(posedge clk) disable iff (!rst_n)
        addr_acc && prev_valid_reg && !prev_last_reg |->
            addr_dst_index == IDX_W'(prev_dst_reg + 1'b1) || addr_dst_index == '0)
        else $error("destination index out of sequence");

endmodule

bind nearest_neighbor_scale_addr_gen_core nnsag_checker u_nnsag_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .addr_valid      (addr.valid),
    .addr_ready      (addr.ready),
    .addr_src_index  (addr.src_index),
    .addr_dst_index  (addr.dst_index),
    .addr_frame_last (addr.frame_last)
);
